/* design/lccf_pkg.sv */
// Shared types, event codes and chord table for the layout chord cycle filter.
package lccf_pkg;

  localparam logic [15:0] EV_SYN      = 16'd0;
  localparam logic [15:0] EV_KEY      = 16'd1;
  localparam logic [15:0] EV_MSC      = 16'd4;
  localparam logic [15:0] CODE_SYNC   = 16'd0;
  localparam logic [15:0] CODE_SCAN   = 16'd4;
  localparam logic [15:0] CODE_LSHIFT = 16'd42;
  localparam logic [15:0] CODE_LALT   = 16'd56;

  localparam logic [3:0] LAYOUT_COUNT_RESET = 4'd3;
  localparam logic [3:0] LAYOUT_COUNT_MIN   = 4'd3;

  typedef enum logic [1:0] {
    PH_START,
    PH_BOTH,
    PH_FINAL
  } phase_t;

  typedef struct packed {
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // One chord is eight items: alt down, shift down, alt up, shift up,
  // each key item followed by a sync report.
  function automatic out_item_t chord_item(input logic [2:0] step);
    out_item_t it;
    it.last = 1'b0;
    if (step[0]) begin
      it.out_type  = EV_SYN;
      it.out_code  = CODE_SYNC;
      it.out_value = 32'sd0;
    end else begin
      it.out_type = EV_KEY;
      unique case (step[2:1])
        2'd0: begin
          it.out_code  = CODE_LALT;
          it.out_value = 32'sd1;
        end
        2'd1: begin
          it.out_code  = CODE_LSHIFT;
          it.out_value = 32'sd1;
        end
        2'd2: begin
          it.out_code  = CODE_LALT;
          it.out_value = 32'sd0;
        end
        default: begin
          it.out_code  = CODE_LSHIFT;
          it.out_value = 32'sd0;
        end
      endcase
    end
    return it;
  endfunction

endpackage

/* design/layout_chord_cycle_filter.sv */
// Top level of the layout chord cycle filter.
//
// Keyboard event filter. Input items (type, code, value) go in on in_push
// while in_full is low; result items come out on out_data while out_empty
// is low and are taken with out_pop. cfg_we writes the layout count from
// cfg_wdata (clamped to 3..MAX_LAYOUTS when used); write it only when idle.
// Misc scan events are dropped with no result. Every other event leaves as
// the final result of its item, with last set. When both modifiers have
// been let go with no re-press, the release is preceded by n alt+shift
// chords (8 items each) that bring the previous layout back.
// A result goes through the command queue and then the output register to the port.
// Throughput: one item per cycle for plain events while out_pop keeps up; an
// item with n chords occupies the emitter for 8n+1 items via the single output register.
// A two-deep command queue lets input run ahead; in_full rises while the
// emitter works through a burst. A stalled receiver holds the output
// register, and the queue fills behind it.
// Reset (synchronous, rst_n low) empties the queue and output register,
// sets layout count 3, current layout 0, previous layout 1.
module layout_chord_cycle_filter #(
  parameter int MAX_LAYOUTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                in_push,
  output logic                in_full,
  input  lccf_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output lccf_pkg::out_item_t out_data
);

  localparam int IDX_W = $clog2(MAX_LAYOUTS);
  localparam int CMD_W = $bits(lccf_pkg::in_item_t) + IDX_W;

  // front to queue
  logic               f_push, q_full;
  lccf_pkg::in_item_t f_item;
  logic [IDX_W-1:0]   f_chords;

  // queue to back
  logic               q_empty, b_pop;
  logic [CMD_W-1:0]   q_data;
  lccf_pkg::in_item_t b_item;
  logic [IDX_W-1:0]   b_chords;

  assign b_item   = lccf_pkg::in_item_t'(q_data[CMD_W-1:IDX_W]);
  assign b_chords = q_data[IDX_W-1:0];

  lccf_front #(
    .MAX_LAYOUTS (MAX_LAYOUTS),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .cmd_push   (f_push),
    .cmd_item   (f_item),
    .cmd_chords (f_chords),
    .cmd_full   (q_full)
  );

  lccf_cmdq #(
    .DATA_W (CMD_W)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_data ({f_item, f_chords}),
    .full    (q_full),
    .rd_en   (b_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  lccf_back #(
    .IDX_W (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_item   (b_item),
    .cmd_chords (b_chords),
    .cmd_empty  (q_empty),
    .cmd_pop    (b_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule

/* design/lccf_cmdq.sv */
// Two-entry command queue between the classifier and the emitter.
module lccf_cmdq #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    count_r, count_nxt;
  logic              do_wr, do_rd;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/lccf_front.sv */
// Front end: accepts events, drops scans, tracks modifiers and layouts, queues commands.
module lccf_front #(
  parameter int MAX_LAYOUTS = 8,
  parameter int IDX_W       = $clog2(MAX_LAYOUTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  lccf_pkg::in_item_t in_data,
  output logic               cmd_push,
  output lccf_pkg::in_item_t cmd_item,
  output logic [IDX_W-1:0]   cmd_chords,
  input  logic               cmd_full
);

  localparam int SW        = IDX_W + 3;
  localparam int MOD_STEPS = MAX_LAYOUTS / 3;

  lccf_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       layout_count_r;
  logic             shift_held_r, shift_held_nxt;
  logic             alt_held_r, alt_held_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  logic             alt_rel_r, alt_rel_nxt;
  logic             shift_rel_r, shift_rel_nxt;
  logic             again_r, again_nxt;

  logic             accept, is_scan, is_key;
  logic             sh, al;
  logic [3:0]       eff;
  logic [IDX_W:0]   wrap;
  logic [IDX_W-1:0] cur_inc;
  logic signed [SW-1:0] cu_s, pl_s, eff_s, diff;
  logic [IDX_W-1:0] chords;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;
  assign is_scan = (in_data.ev_type == lccf_pkg::EV_MSC) &&
                   (in_data.ev_code == lccf_pkg::CODE_SCAN);
  assign is_key  = (in_data.ev_type == lccf_pkg::EV_KEY);

  // held status as updated by this event
  assign sh = (is_key && in_data.ev_code == lccf_pkg::CODE_LSHIFT) ?
              (in_data.ev_value != 32'sd0) : shift_held_r;
  assign al = (is_key && in_data.ev_code == lccf_pkg::CODE_LALT) ?
              (in_data.ev_value != 32'sd0) : alt_held_r;

  // clamp the configured count into range
  always_comb begin
    eff = layout_count_r;
    if (eff < lccf_pkg::LAYOUT_COUNT_MIN) begin
      eff = lccf_pkg::LAYOUT_COUNT_MIN;
    end
    if (eff > 4'(MAX_LAYOUTS)) begin
      eff = 4'(MAX_LAYOUTS);
    end
  end

  // (cur + 1) mod eff; cur may exceed eff after a count change
  always_comb begin
    wrap = {1'b0, cur_r} + 1'b1;
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (4'(wrap) >= eff) begin
        wrap = wrap - (IDX_W+1)'(eff);
      end
    end
    cur_inc = wrap[IDX_W-1:0];
  end

  // chords needed to get back to the previous layout
  always_comb begin
    cu_s  = $signed({3'b000, cur_r});
    pl_s  = $signed({3'b000, prev_r});
    eff_s = $signed({{(SW-4){1'b0}}, eff});
    if (pl_s > cu_s) begin
      diff = pl_s - cu_s - SW'(1);
    end else begin
      diff = pl_s + eff_s - cu_s - SW'(1);
    end
    if (diff < 0) begin
      chords = '0;
    end else if (diff > SW'(MAX_LAYOUTS - 1)) begin
      chords = IDX_W'(MAX_LAYOUTS - 1);
    end else begin
      chords = diff[IDX_W-1:0];
    end
  end

  // next state of the phase machine
  always_comb begin
    phase_nxt = phase_r;
    if (accept && !is_scan) begin
      unique case (phase_r)
        lccf_pkg::PH_BOTH:  phase_nxt = (!al && !sh) ? lccf_pkg::PH_FINAL : lccf_pkg::PH_BOTH;
        lccf_pkg::PH_FINAL: phase_nxt = lccf_pkg::PH_START;
        default:            phase_nxt = (sh && al) ? lccf_pkg::PH_BOTH : lccf_pkg::PH_START;
      endcase
    end
  end

  // tracking state and command outputs
  always_comb begin
    shift_held_nxt = shift_held_r;
    alt_held_nxt   = alt_held_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    alt_rel_nxt    = alt_rel_r;
    shift_rel_nxt  = shift_rel_r;
    again_nxt      = again_r;
    cmd_push       = 1'b0;
    cmd_item       = in_data;
    cmd_chords     = '0;
    if (accept && !is_scan) begin
      cmd_push       = 1'b1;
      shift_held_nxt = sh;
      alt_held_nxt   = al;
      unique case (phase_r)
        lccf_pkg::PH_BOTH: begin
          if (!sh) begin
            shift_rel_nxt = 1'b1;
          end else if (!al) begin
            alt_rel_nxt = 1'b1;
          end
          if (alt_rel_nxt) begin
            if (al) begin
              alt_rel_nxt = 1'b0;
              again_nxt   = 1'b1;
              prev_nxt    = cur_r;
              cur_nxt     = cur_inc;
            end
          end else if (shift_rel_nxt) begin
            if (sh) begin
              shift_rel_nxt = 1'b0;
              again_nxt     = 1'b1;
              prev_nxt      = cur_r;
              cur_nxt       = cur_inc;
            end
          end
        end
        lccf_pkg::PH_FINAL: begin
          if (!again_r) begin
            cmd_chords = chords;
            cur_nxt    = prev_r;
            prev_nxt   = cur_r;
          end
          alt_rel_nxt   = 1'b0;
          shift_rel_nxt = 1'b0;
          again_nxt     = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= lccf_pkg::PH_START;
      layout_count_r <= lccf_pkg::LAYOUT_COUNT_RESET;
      shift_held_r   <= 1'b0;
      alt_held_r     <= 1'b0;
      cur_r          <= '0;
      prev_r         <= IDX_W'(1);
      alt_rel_r      <= 1'b0;
      shift_rel_r    <= 1'b0;
      again_r        <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      shift_held_r <= shift_held_nxt;
      alt_held_r   <= alt_held_nxt;
      cur_r        <= cur_nxt;
      prev_r       <= prev_nxt;
      alt_rel_r    <= alt_rel_nxt;
      shift_rel_r  <= shift_rel_nxt;
      again_r      <= again_nxt;
      if (cfg_we) begin
        layout_count_r <= cfg_wdata;
      end
    end
  end

endmodule

/* design/lccf_back.sv */
// Back end: plays out chord items then the passed-through event into the output register.
module lccf_back #(
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lccf_pkg::in_item_t  cmd_item,
  input  logic [IDX_W-1:0]    cmd_chords,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output lccf_pkg::out_item_t out_data
);

  lccf_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    chord_r, chord_nxt;
  logic [2:0]          step_r, step_nxt;
  logic                load;

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign load      = !out_valid_r || out_pop;

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    chord_nxt     = chord_r;
    step_nxt      = step_r;
    cmd_pop       = 1'b0;
    if (load && !cmd_empty) begin
      out_valid_nxt = 1'b1;
      if (chord_r < cmd_chords) begin
        out_nxt  = lccf_pkg::chord_item(step_r);
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd7) begin
          chord_nxt = chord_r + 1'b1;
        end
      end else begin
        out_nxt.out_type  = cmd_item.ev_type;
        out_nxt.out_code  = cmd_item.ev_code;
        out_nxt.out_value = cmd_item.ev_value;
        out_nxt.last      = 1'b1;
        cmd_pop           = 1'b1;
        chord_nxt         = '0;
        step_nxt          = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      chord_r     <= '0;
      step_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      chord_r     <= chord_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
